// ===== src/tcptmr_pkg.sv =====
package tcptmr_pkg;

  // Timer action reported per connection record
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_RETX     = 3'd1,
    ACT_RST_FREE = 3'd2,
    ACT_FREE     = 3'd3,
    ACT_FIN      = 3'd4
  } action_e;

  // Connection state codes
  localparam logic [3:0] ST_CLOSED      = 4'd0;
  localparam logic [3:0] ST_LISTEN      = 4'd1;
  localparam logic [3:0] ST_SYN_SENT    = 4'd2;
  localparam logic [3:0] ST_SYN_RCVD    = 4'd3;
  localparam logic [3:0] ST_ESTAB       = 4'd4;
  localparam logic [3:0] ST_FIN_WAIT1   = 4'd5;
  localparam logic [3:0] ST_FIN_WAIT2   = 4'd6;
  localparam logic [3:0] ST_CLOSE_WAIT  = 4'd7;
  localparam logic [3:0] ST_CLOSING     = 4'd8;
  localparam logic [3:0] ST_LAST_ACK    = 4'd9;
  localparam logic [3:0] ST_TIME_WAIT   = 4'd10;

  // Request types
  localparam logic REQ_TIME = 1'b0;
  localparam logic REQ_CONN = 1'b1;

  // Register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 40;
  localparam logic [CfgIdxW-1:0] REG_RETX_INTERVAL    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TIME_WAIT_LIMIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IDLE_LIMIT       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CLOSE_WAIT_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RETX_CAP         = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TSC_PER_TICK     = 3'd5;

  // Register reset values
  localparam logic [31:0] RETX_INTERVAL_RST    = 32'd1000;
  localparam logic [31:0] TIME_WAIT_LIMIT_RST  = 32'd4000;
  localparam logic [31:0] IDLE_LIMIT_RST       = 32'd30000;
  localparam logic [31:0] CLOSE_WAIT_LIMIT_RST = 32'd2000;
  localparam logic [7:0]  RETX_CAP_RST         = 8'd8;
  localparam logic [39:0] TSC_PER_TICK_RST     = 40'd2400000;

  // Limits that the judge needs
  typedef struct packed {
    logic [31:0] retx_interval;
    logic [31:0] time_wait_limit;
    logic [31:0] idle_limit;
    logic [31:0] close_wait_limit;
    logic [7:0]  retx_cap;
  } limits_t;

  // One connection record
  typedef struct packed {
    logic [3:0]  conn_state;
    logic [31:0] unacked_seq;
    logic [31:0] next_seq;
    logic [31:0] last_send_tick;
    logic [31:0] time_wait_start;
    logic [7:0]  retx_tries;
    logic        is_protected;
  } conn_t;

  // Judge verdict
  typedef struct packed {
    action_e    action;
    logic [7:0] new_retx_tries;
  } verdict_t;

endpackage

// ===== src/tcptmr_judge.sv =====
module tcptmr_judge (
  input  tcptmr_pkg::limits_t  limits_i,
  input  tcptmr_pkg::conn_t    conn_i,
  input  logic [31:0]          now_tick_i,
  output tcptmr_pkg::verdict_t verdict_o
);

  logic [31:0] gap;
  logic [31:0] sent_el;
  logic [31:0] tw_el;
  logic        pending;
  logic        acked;
  logic        retx_due;
  logic [7:0]  tries_inc;

  // Elapsed ticks wrap at 32 bits
  assign sent_el   = now_tick_i - conn_i.last_send_tick;
  assign tw_el     = now_tick_i - conn_i.time_wait_start;
  assign gap       = conn_i.next_seq - conn_i.unacked_seq;
  assign acked     = (gap == 32'd0);
  assign pending   = !acked && !gap[31];
  assign retx_due  = pending && (sent_el > limits_i.retx_interval);
  assign tries_inc = (conn_i.retx_tries == 8'hFF) ? 8'hFF : conn_i.retx_tries + 8'd1;

  always_comb begin
    verdict_o.action         = tcptmr_pkg::ACT_NONE;
    verdict_o.new_retx_tries = conn_i.retx_tries;
    case (conn_i.conn_state) inside
      tcptmr_pkg::ST_SYN_SENT, tcptmr_pkg::ST_SYN_RCVD, tcptmr_pkg::ST_ESTAB: begin
        if (retx_due) begin
          if (conn_i.retx_tries >= limits_i.retx_cap) begin
            verdict_o.action = tcptmr_pkg::ACT_RST_FREE;
          end else begin
            verdict_o.action         = tcptmr_pkg::ACT_RETX;
            verdict_o.new_retx_tries = tries_inc;
          end
        end else if (conn_i.conn_state == tcptmr_pkg::ST_ESTAB && acked &&
                     sent_el > limits_i.idle_limit && !conn_i.is_protected) begin
          // idle reap
          verdict_o.action = tcptmr_pkg::ACT_RST_FREE;
        end
      end
      tcptmr_pkg::ST_CLOSE_WAIT: begin
        if (sent_el > limits_i.close_wait_limit && !conn_i.is_protected) begin
          verdict_o.action = tcptmr_pkg::ACT_FIN;
        end
      end
      tcptmr_pkg::ST_FIN_WAIT1, tcptmr_pkg::ST_FIN_WAIT2,
      tcptmr_pkg::ST_CLOSING, tcptmr_pkg::ST_LAST_ACK: begin
        // stalled close, freed even when protected
        if (sent_el > limits_i.idle_limit) begin
          verdict_o.action = tcptmr_pkg::ACT_FREE;
        end
      end
      tcptmr_pkg::ST_TIME_WAIT: begin
        if (tw_el > limits_i.time_wait_limit) begin
          verdict_o.action = tcptmr_pkg::ACT_FREE;
        end
      end
      default: begin
        verdict_o.action = tcptmr_pkg::ACT_NONE;
      end
    endcase
  end

endmodule

// ===== src/tcp_connection_timer_policy.sv =====
// TCP connection timer policy. Each input beat is either a time sample
// (req_type 0) or a connection record (req_type 1) and yields exactly one
// result beat. A nonzero time sample advances the tick counter once the time
// stamp has moved on by at least tsc_per_tick since the last latched sample
// (the first one only latches); a zero sample always advances it. A record
// is judged against the current tick with wrapping 32-bit elapsed times. The
// block takes one beat per cycle while its result is not stalled. An accepted
// beat sits in the input register, then moves into the result register and
// drives out_valid_o from then on; a stalled result holds both registers.
// Tick state is updated as a beat moves from the input register to the
// result register, so every record sees the ticks of all earlier samples.
// Write configuration registers only while no beat is in flight.
module tcp_connection_timer_policy #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [tcptmr_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tcptmr_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  req_type_i,
  input  logic [63:0]                           tsc_now_i,
  input  logic [3:0]                            conn_state_i,
  input  logic [31:0]                           unacked_seq_i,
  input  logic [31:0]                           next_seq_i,
  input  logic [31:0]                           last_send_tick_i,
  input  logic [31:0]                           time_wait_start_i,
  input  logic [7:0]                            retx_tries_i,
  input  logic                                  is_protected_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [2:0]                            action_o,
  output logic [7:0]                            new_retx_tries_o,
  output logic                                  tick_advanced_o,
  output logic [31:0]                           now_tick_o
);

  // Configuration registers
  tcptmr_pkg::limits_t limits_q;
  logic [39:0]         tsc_per_tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.retx_interval    <= tcptmr_pkg::RETX_INTERVAL_RST;
      limits_q.time_wait_limit  <= tcptmr_pkg::TIME_WAIT_LIMIT_RST;
      limits_q.idle_limit       <= tcptmr_pkg::IDLE_LIMIT_RST;
      limits_q.close_wait_limit <= tcptmr_pkg::CLOSE_WAIT_LIMIT_RST;
      limits_q.retx_cap         <= tcptmr_pkg::RETX_CAP_RST;
      tsc_per_tick_q            <= tcptmr_pkg::TSC_PER_TICK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcptmr_pkg::REG_RETX_INTERVAL:    limits_q.retx_interval    <= cfg_wdata_i[31:0];
        tcptmr_pkg::REG_TIME_WAIT_LIMIT:  limits_q.time_wait_limit  <= cfg_wdata_i[31:0];
        tcptmr_pkg::REG_IDLE_LIMIT:       limits_q.idle_limit       <= cfg_wdata_i[31:0];
        tcptmr_pkg::REG_CLOSE_WAIT_LIMIT: limits_q.close_wait_limit <= cfg_wdata_i[31:0];
        tcptmr_pkg::REG_RETX_CAP:         limits_q.retx_cap         <= cfg_wdata_i[7:0];
        tcptmr_pkg::REG_TSC_PER_TICK:     tsc_per_tick_q            <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic                in_vld_q;
  logic                req_type_q;
  logic [63:0]         tsc_now_q;
  tcptmr_pkg::conn_t   conn_q;
  logic                adv;
  logic                in_load;

  // result stage moves when empty or its beat is taken
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_vld_q && !adv;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv || !in_vld_q) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      req_type_q             <= req_type_i;
      tsc_now_q              <= tsc_now_i;
      conn_q.conn_state      <= conn_state_i;
      conn_q.unacked_seq     <= unacked_seq_i;
      conn_q.next_seq        <= next_seq_i;
      conn_q.last_send_tick  <= last_send_tick_i;
      conn_q.time_wait_start <= time_wait_start_i;
      conn_q.retx_tries      <= retx_tries_i;
      conn_q.is_protected    <= is_protected_i;
    end
  end

  // Tick state
  logic [63:0]          last_cyc_q, last_cyc_d;
  logic [TICK_BITS-1:0] tick_q, tick_d;
  logic [63:0]          base_cyc;
  logic [63:0]          cyc_diff;
  logic                 go;
  logic                 fire;
  logic                 is_time;

  assign fire    = in_vld_q && adv;
  assign is_time = (req_type_q == tcptmr_pkg::REQ_TIME);

  // throttle: first nonzero sample latches, zero sample always advances
  always_comb begin
    base_cyc   = (last_cyc_q == 64'd0) ? tsc_now_q : last_cyc_q;
    cyc_diff   = tsc_now_q - base_cyc;
    go         = 1'b1;
    last_cyc_d = last_cyc_q;
    if (tsc_now_q != 64'd0) begin
      if (cyc_diff < {24'd0, tsc_per_tick_q}) begin
        go         = 1'b0;
        last_cyc_d = base_cyc;
      end else begin
        last_cyc_d = tsc_now_q;
      end
    end
    tick_d = go ? tick_q + TICK_BITS'(1) : tick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cyc_q <= 64'd0;
      tick_q     <= '0;
    end else if (fire && is_time) begin
      last_cyc_q <= last_cyc_d;
      tick_q     <= tick_d;
    end
  end

  // Connection judge
  tcptmr_pkg::verdict_t verdict;

  tcptmr_judge u_judge (
    .limits_i   (limits_q),
    .conn_i     (conn_q),
    .now_tick_i (32'(tick_q)),
    .verdict_o  (verdict)
  );

  // Result register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (is_time) begin
        action_o         <= tcptmr_pkg::ACT_NONE;
        new_retx_tries_o <= 8'd0;
        tick_advanced_o  <= go;
        now_tick_o       <= 32'(tick_d);
      end else begin
        action_o         <= verdict.action;
        new_retx_tries_o <= verdict.new_retx_tries;
        tick_advanced_o  <= 1'b0;
        now_tick_o       <= 32'(tick_q);
      end
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== src/tcptmr_checker.sv =====
module tcptmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  action_o,
  input logic [7:0]  new_retx_tries_o,
  input logic        tick_advanced_o,
  input logic [31:0] now_tick_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) &&
    $stable(new_retx_tries_o) && $stable(tick_advanced_o) && $stable(now_tick_o))
    else $error("stalled result beat changed");

  // only the five defined actions appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> action_o <= 3'(tcptmr_pkg::ACT_FIN))
    else $error("undefined action code");

  // a tick advance comes from a time sample, which carries no action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tick_advanced_o |->
    action_o == 3'(tcptmr_pkg::ACT_NONE) && new_retx_tries_o == 8'd0)
    else $error("tick advance on a connection verdict");

  // a retransmit always counts at least one try
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == 3'(tcptmr_pkg::ACT_RETX) |-> new_retx_tries_o != 8'd0)
    else $error("retransmit without a try count");

endmodule

bind tcp_connection_timer_policy tcptmr_checker u_tcptmr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .action_o         (action_o),
  .new_retx_tries_o (new_retx_tries_o),
  .tick_advanced_o  (tick_advanced_o),
  .now_tick_o       (now_tick_o)
);
